[rtl/draw_command_frame_validator_defines.svh]
// Assertion macros for the draw-command frame validator.
`ifndef DRAW_COMMAND_FRAME_VALIDATOR_DEFINES_SVH
`define DRAW_COMMAND_FRAME_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DCFV_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dcfv check failed");
`define DCFV_CHECK_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dcfv reset check failed");
`else
`define DCFV_CHECK(lbl, prop)
`define DCFV_CHECK_RST(lbl, prop)
`endif
`endif

[rtl/dcfv_pkg.sv]
// Shared types, codes and tables of the draw-command frame validator.
package dcfv_pkg;

    localparam int DCFV_QUEUE_DEPTH = 2;
    localparam logic [19:0] DCFV_MAX_OPS_RESET = 20'd100000;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_OPHDR   = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_TAIL    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [3:0] E_OK        = 4'd0;
    localparam logic [3:0] E_SHORT     = 4'd1;
    localparam logic [3:0] E_MAGIC     = 4'd2;
    localparam logic [3:0] E_VERSION   = 4'd3;
    localparam logic [3:0] E_HDRLEN    = 4'd4;
    localparam logic [3:0] E_ZERODIM   = 4'd5;
    localparam logic [3:0] E_OPCOUNT   = 4'd6;
    localparam logic [3:0] E_TRUNC_HDR = 4'd7;
    localparam logic [3:0] E_TRUNC_PL  = 4'd8;
    localparam logic [3:0] E_PL_LEN    = 4'd9;
    localparam logic [3:0] E_TEXT      = 4'd10;
    localparam logic [3:0] E_IMAGE     = 4'd11;
    localparam logic [3:0] E_RECT_CNT  = 4'd12;
    localparam logic [3:0] E_RECT_DIM  = 4'd13;
    localparam logic [3:0] E_OPCODE    = 4'd14;
    localparam logic [3:0] E_TRAILING  = 4'd15;

    localparam logic [3:0] CFG_MAX_OPS = 4'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    magic_byte = 8'h4F;
            2'd1:    magic_byte = 8'h47;
            2'd2:    magic_byte = 8'h46;
            default: magic_byte = 8'h30;
        endcase
    endfunction

    function automatic logic [3:0] length_rule(input logic [7:0] op, input logic [15:0] pl);
        logic [15:0] pm;
        pm = pl - 16'd8;
        case (op)
            8'd1, 8'd4, 8'd65: length_rule = (pl != 16'd20) ? E_PL_LEN : E_OK;
            8'd3:              length_rule = (pl != 16'd24) ? E_PL_LEN : E_OK;
            8'd5:              length_rule = (pl != 16'd28) ? E_PL_LEN : E_OK;
            8'd69:             length_rule = (pl != 16'd12) ? E_PL_LEN : E_OK;
            8'd66, 8'd70:      length_rule = (pl != 16'd4) ? E_PL_LEN : E_OK;
            8'd67:             length_rule = (pl != 16'd36) ? E_PL_LEN : E_OK;
            8'd2, 8'd64:       length_rule = (pl < 16'd16) ? E_PL_LEN : E_OK;
            8'd68:             length_rule = (pl < 16'd12) ? E_PL_LEN : E_OK;
            8'd71: length_rule = (pl < 16'd40 || pm[4:0] != 5'd0) ? E_PL_LEN : E_OK;
            default:           length_rule = E_OPCODE;
        endcase
    endfunction

endpackage

[rtl/draw_command_frame_validator.sv]
// Draw-command frame validator top level: byte stream in, one verdict per frame out.
//
// Bytes of a frame arrive on the s_axis channel, one per transfer, from offset
// zero, with tlast on the final byte. A short ingress queue feeds a parser that takes
// one byte per cycle, so the block sustains one byte every cycle unless m_axis stalls.
// Each frame gives a single transfer on m_axis once its last byte has passed the queue
// and the parser: bit 0 is frame_ok, bits 4:1 the class of the first failure.
// Bytes other than the last give no result.
// When the m_axis receiver stalls, the verdict waits in the output register;
// the parser then stops and the queue fills, after which s_axis tready drops.
// The operation-count limit register is written through the APB port at address 0
// and reads back there; it should only be written while no frame is in flight.
// Reset (synchronous, active low) empties the queue, drops any pending
// verdict, returns the parser to the start of a frame and reloads
// the operation-count limit with 100000.
module draw_command_frame_validator
    import dcfv_pkg::*;
#(
    parameter int QUEUE_DEPTH = DCFV_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  logic        i_s_axis_tlast,    // frame_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,    // [0] frame_ok, [4:1] error_code, [7:5] zero
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    logic [19:0] r_max_ops;
    t_item       in_item, q_item;
    logic        q_valid, q_ready;
    logic        ok;
    logic [3:0]  code;
    logic        cfg_wr;

    assign in_item.data = i_s_axis_tdata;
    assign in_item.last = i_s_axis_tlast;
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready &&
                      ({1'b0, i_paddr[2]} == CFG_MAX_OPS[1:0]);
    assign o_prdata = ({1'b0, i_paddr[2]} == CFG_MAX_OPS[1:0]) ? {12'd0, r_max_ops} : 32'd0;
    assign o_m_axis_tdata = {3'd0, code, ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ops <= DCFV_MAX_OPS_RESET;
        end else if (cfg_wr) begin
            r_max_ops <= i_pwdata[19:0];
        end
    end

    dcfv_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    dcfv_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_ops (r_max_ops),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_item    (q_item),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_ok      (ok),
        .o_code    (code)
    );

`include "draw_command_frame_validator_defines.svh"

    `DCFV_CHECK(a_ok_matches_code, o_m_axis_tvalid |-> (ok == (code == E_OK)))
    `DCFV_CHECK_RST(a_reset_clears_out, !i_rst_n |=> !o_m_axis_tvalid)
    `DCFV_CHECK(a_cfg_readback, cfg_wr |=> (r_max_ops == $past(i_pwdata[19:0])))
endmodule

[rtl/dcfv_front.sv]
// Ingress side: accepts frame bytes and holds them in a short queue for the parser.
module dcfv_front
    import dcfv_pkg::*;
#(
    parameter int DEPTH = DCFV_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

[rtl/dcfv_parse.sv]
// Back side: byte-level frame parser with a registered verdict output.
module dcfv_parse
    import dcfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [19:0] i_max_ops,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [3:0]  o_code
);
    logic [2:0]  r_phase, n_phase;
    logic [5:0]  r_hpos, n_hpos;
    logic [31:0] r_acc, n_acc;
    logic        r_flag, n_flag;
    logic [31:0] r_ops, n_ops;
    logic [7:0]  r_op, n_op;
    logic [15:0] r_pl, n_pl;
    logic [15:0] r_ppos, n_ppos;
    logic [31:0] r_width, n_width;
    logic        r_hzero, n_hzero;
    logic        r_abig, n_abig;
    logic [13:0] r_area, n_area;
    logic [3:0]  r_pend, n_pend;
    logic        r_ovalid;
    logic [3:0]  r_ocode;

    logic        step;
    logic [7:0]  b;
    logic [31:0] w;
    logic [3:0]  c;
    logic [15:0] off, offr;
    logic [31:0] pl32;
    logic [31:0] ops_dec;
    logic [63:0] prod;
    logic [16:0] ppos_inc;
    logic [3:0]  end_code;
    logic        finish;

    assign o_ready = !r_ovalid || i_ready;
    assign step    = i_valid && o_ready;
    assign b       = i_item.data;
    assign w       = {b, r_acc[31:8]};
    assign off     = r_ppos - 16'd3;
    assign offr    = off - 16'd8;
    assign pl32    = {16'd0, r_pl};
    assign ops_dec = r_ops - 32'd1;
    assign prod    = {32'd0, r_width} * {32'd0, w};
    assign ppos_inc = {1'b0, r_ppos} + 17'd1;

    assign o_valid = r_ovalid;
    assign o_code  = r_ocode;
    assign o_ok    = (r_ocode == E_OK);

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_acc   = r_acc;
        n_flag  = r_flag;
        n_ops   = r_ops;
        n_op    = r_op;
        n_pl    = r_pl;
        n_ppos  = r_ppos;
        n_width = r_width;
        n_hzero = r_hzero;
        n_abig  = r_abig;
        n_area  = r_area;
        c       = E_OK;
        finish  = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                n_acc = w;
                if (r_hpos < 6'd4 && b != magic_byte(r_hpos[1:0])) c = E_MAGIC;
                if (r_hpos == 6'd4 && b != 8'd1) c = E_VERSION;
                if (r_hpos == 6'd7 && w[31:16] != 16'd40) c = E_HDRLEN;
                if ((r_hpos == 6'd11 || r_hpos == 6'd15 || r_hpos == 6'd19 ||
                     r_hpos == 6'd31 || r_hpos == 6'd35) && w == 32'd0) c = E_ZERODIM;
                if (r_hpos == 6'd23) begin
                    n_ops  = w;
                    n_flag = r_flag | (w > {12'd0, i_max_ops});
                end
                if (r_hpos == 6'd39 && r_flag) c = E_OPCOUNT;
                n_hpos = r_hpos + 6'd1;
            end
            PH_OPHDR: begin
                if (r_hpos == 6'd0) n_op = b;
                if (r_hpos == 6'd2) n_pl = {8'd0, b};
                if (r_hpos == 6'd3) n_pl = {b, r_pl[7:0]};
                n_hpos = r_hpos + 6'd1;
                if (r_hpos == 6'd3) begin
                    n_hpos = 6'd0;
                    n_ppos = 16'd0;
                    n_acc  = 32'd0;
                    c      = length_rule(r_op, n_pl);
                    if (n_pl == 16'd0) finish = 1'b1;
                    else n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_acc = w;
                if (r_ppos[1:0] == 2'd3 && r_pend == E_OK) begin
                    case (r_op)
                        8'd2: if (off == 16'd12 && w != pl32 - 32'd16) c = E_TEXT;
                        8'd68: if (off == 16'd8 && w != pl32 - 32'd12) c = E_TEXT;
                        8'd64: begin
                            if (off == 16'd4) n_width = w;
                            else if (off == 16'd8) begin
                                n_hzero = (w == 32'd0);
                                n_abig  = |prod[63:14];
                                n_area  = prod[13:0];
                            end else if (off == 16'd12) begin
                                if (r_width == 32'd0 || r_hzero || w != pl32 - 32'd16 ||
                                    r_abig || w != {16'd0, r_area, 2'b00}) c = E_IMAGE;
                            end
                        end
                        8'd67: if ((off == 16'd12 || off == 16'd16 || off == 16'd28 ||
                                   off == 16'd32) && w == 32'd0) c = E_RECT_DIM;
                        8'd71: begin
                            if (off == 16'd4) begin
                                if (w == 32'd0 || w != ((pl32 - 32'd8) >> 5)) c = E_RECT_CNT;
                            end else if (off >= 16'd8) begin
                                if ((offr[4:0] == 5'd8 || offr[4:0] == 5'd12 ||
                                     offr[4:0] == 5'd24 || offr[4:0] == 5'd28) &&
                                    w == 32'd0) c = E_RECT_DIM;
                            end
                        end
                        default: c = E_OK;
                    endcase
                end
                if (ppos_inc >= {1'b0, r_pl}) finish = 1'b1;
                else n_ppos = ppos_inc[15:0];
            end
            PH_TAIL: begin
                c       = E_TRAILING;
                n_phase = PH_ERROR;
            end
            default: c = E_OK;
        endcase

        n_pend = (r_pend != E_OK) ? r_pend : c;

        // Header end and op end both move on to the next op, to the tail, or to the error state.
        if (r_phase == PH_HEADER && r_hpos == 6'd39) begin
            n_hpos = 6'd0;
            n_acc  = 32'd0;
            if (n_pend != E_OK) n_phase = PH_ERROR;
            else n_phase = (r_ops == 32'd0) ? PH_TAIL : PH_OPHDR;
        end
        if (finish) begin
            n_hpos = 6'd0;
            n_acc  = 32'd0;
            if (n_pend != E_OK) begin
                n_phase = PH_ERROR;
            end else begin
                n_ops   = ops_dec;
                n_phase = (ops_dec == 32'd0) ? PH_TAIL : PH_OPHDR;
            end
        end

        case (n_phase)
            PH_HEADER:  end_code = E_SHORT;
            PH_OPHDR:   end_code = E_TRUNC_HDR;
            PH_PAYLOAD: end_code = E_TRUNC_PL;
            PH_TAIL:    end_code = E_OK;
            default:    end_code = n_pend;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (step && i_item.last) begin
            r_ocode <= end_code;
        end
        r_width <= (step && !i_item.last) ? n_width : r_width;
        r_hzero <= (step && !i_item.last) ? n_hzero : r_hzero;
        r_abig  <= (step && !i_item.last) ? n_abig : r_abig;
        r_area  <= (step && !i_item.last) ? n_area : r_area;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hpos   <= '0;
            r_acc    <= '0;
            r_flag   <= 1'b0;
            r_ops    <= '0;
            r_op     <= '0;
            r_pl     <= '0;
            r_ppos   <= '0;
            r_pend   <= E_OK;
            r_ovalid <= 1'b0;
        end else begin
            // A new verdict may replace the one leaving in the same cycle.
            if (step && i_item.last) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (step) begin
                if (i_item.last) begin
                    r_phase  <= PH_HEADER;
                    r_hpos   <= '0;
                    r_acc    <= '0;
                    r_flag   <= 1'b0;
                    r_ops    <= '0;
                    r_op     <= '0;
                    r_pl     <= '0;
                    r_ppos   <= '0;
                    r_pend   <= E_OK;
                end else begin
                    r_phase <= n_phase;
                    r_hpos  <= n_hpos;
                    r_acc   <= n_acc;
                    r_flag  <= n_flag;
                    r_ops   <= n_ops;
                    r_op    <= n_op;
                    r_pl    <= n_pl;
                    r_ppos  <= n_ppos;
                    r_pend  <= n_pend;
                end
            end
        end
    end
endmodule

[dv/dcfv_ops_pkg.sv]
`timescale 1ns / 100ps
// Opcode names of the draw-command frame format, shared by the checker and the stimulus.
package dcfv_ops_pkg;

    localparam logic [7:0] OP_FIX20_A   = 8'd1;
    localparam logic [7:0] OP_TEXT      = 8'd2;
    localparam logic [7:0] OP_FIX24     = 8'd3;
    localparam logic [7:0] OP_FIX20_B   = 8'd4;
    localparam logic [7:0] OP_FIX28     = 8'd5;
    localparam logic [7:0] OP_IMAGE     = 8'd64;
    localparam logic [7:0] OP_FIX20_C   = 8'd65;
    localparam logic [7:0] OP_FIX4_A    = 8'd66;
    localparam logic [7:0] OP_BOX       = 8'd67;
    localparam logic [7:0] OP_TEXT_RUN  = 8'd68;
    localparam logic [7:0] OP_FIX12     = 8'd69;
    localparam logic [7:0] OP_FIX4_B    = 8'd70;
    localparam logic [7:0] OP_RECT_LIST = 8'd71;

endpackage

[dv/dcfv_verdict_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts frame verdicts from accepted bytes and compares them with the block.
module dcfv_verdict_checker
    import dcfv_pkg::*;
    import dcfv_ops_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic       ok;
        logic [3:0] code;
    } t_verdict;

    t_verdict    verdicts_due[$];
    int          fails;
    logic [19:0] max_ops;
    logic [2:0]  phase;
    logic [5:0]  hpos;
    logic [31:0] acc;
    logic        too_many_ops;
    logic [31:0] ops_left;
    logic [7:0]  opcode;
    logic [15:0] plen;
    logic [15:0] ppos;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic [3:0]  first_err;

    function automatic void clear_frame();
        phase = PH_HEADER;
        hpos = '0;
        acc = '0;
        too_many_ops = 1'b0;
        ops_left = '0;
        opcode = '0;
        plen = '0;
        ppos = '0;
        img_w = '0;
        img_h = '0;
        first_err = E_OK;
    endfunction

    function automatic void note(input logic [3:0] code);
        if (first_err == E_OK) first_err = code;
    endfunction

    function automatic logic [3:0] length_error(input logic [7:0] op, input logic [31:0] pl);
        case (op)
            OP_FIX20_A, OP_FIX20_B, OP_FIX20_C: return (pl != 20) ? E_PL_LEN : E_OK;
            OP_FIX24:     return (pl != 24) ? E_PL_LEN : E_OK;
            OP_FIX28:     return (pl != 28) ? E_PL_LEN : E_OK;
            OP_FIX12:     return (pl != 12) ? E_PL_LEN : E_OK;
            OP_FIX4_A, OP_FIX4_B: return (pl != 4) ? E_PL_LEN : E_OK;
            OP_BOX:       return (pl != 36) ? E_PL_LEN : E_OK;
            OP_TEXT, OP_IMAGE: return (pl < 16) ? E_PL_LEN : E_OK;
            OP_TEXT_RUN:  return (pl < 12) ? E_PL_LEN : E_OK;
            OP_RECT_LIST: return (pl < 40 || ((pl - 8) % 32) != 0) ? E_PL_LEN : E_OK;
            default:      return E_OPCODE;
        endcase
    endfunction

    function automatic void end_op();
        hpos = '0;
        acc = '0;
        if (first_err != E_OK) begin
            phase = PH_ERROR;
        end else begin
            ops_left = ops_left - 1;
            phase = (ops_left == 0) ? PH_TAIL : PH_OPHDR;
        end
    endfunction

    function automatic void check_payload_word(input logic [31:0] off, input logic [31:0] w);
        logic [31:0] pl;
        logic [63:0] area;
        logic [31:0] r;
        pl = {16'd0, plen};
        case (opcode)
            OP_TEXT: if (off == 12 && w != pl - 32'd16) note(E_TEXT);
            OP_TEXT_RUN: if (off == 8 && w != pl - 32'd12) note(E_TEXT);
            OP_IMAGE: begin
                if (off == 4) begin
                    img_w = w;
                end else if (off == 8) begin
                    img_h = w;
                end else if (off == 12) begin
                    area = {32'd0, img_w} * {32'd0, img_h};
                    if (img_w == 0 || img_h == 0 || w != pl - 32'd16 || area > 64'd16383 ||
                        area * 64'd4 != {32'd0, w})
                        note(E_IMAGE);
                end
            end
            OP_BOX: if ((off == 12 || off == 16 || off == 28 || off == 32) && w == 0)
                note(E_RECT_DIM);
            OP_RECT_LIST: begin
                if (off == 4) begin
                    if (w == 0 || w != (pl - 32'd8) / 32'd32) note(E_RECT_CNT);
                end else if (off >= 8) begin
                    r = (off - 32'd8) & 32'd31;
                    if ((r == 8 || r == 12 || r == 24 || r == 28) && w == 0) note(E_RECT_DIM);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] magic_at(input logic [1:0] i);
        case (i)
            2'd0:    return 8'h4F;
            2'd1:    return 8'h47;
            2'd2:    return 8'h46;
            default: return 8'h30;
        endcase
    endfunction

    // Advances the frame parser by one byte; returns 1 with the verdict on the last byte.
    function automatic logic parse_byte(input logic [7:0] b, input logic last,
                                        output t_verdict v);
        logic [31:0] pos;
        pos = '0;
        case (phase)
            PH_HEADER: begin
                pos = {26'd0, hpos};
                acc = {b, acc[31:8]};
                if (pos < 4 && b != magic_at(pos[1:0])) note(E_MAGIC);
                if (pos == 4 && b != 8'd1) note(E_VERSION);
                if (pos == 7 && acc[31:16] != 16'd40) note(E_HDRLEN);
                if (pos[1:0] == 2'd3) begin
                    if ((pos == 11 || pos == 15 || pos == 19 || pos == 31 || pos == 35) &&
                        acc == 0)
                        note(E_ZERODIM);
                    if (pos == 23) begin
                        ops_left = acc;
                        if (acc > {12'd0, max_ops}) too_many_ops = 1'b1;
                    end
                end
                if (pos == 39) begin
                    if (too_many_ops) note(E_OPCOUNT);
                    hpos = '0;
                    acc = '0;
                    if (first_err != E_OK) phase = PH_ERROR;
                    else phase = (ops_left == 0) ? PH_TAIL : PH_OPHDR;
                end else begin
                    hpos = hpos + 1;
                end
            end
            PH_OPHDR: begin
                if (hpos == 0) opcode = b;
                else if (hpos == 2) plen = {8'd0, b};
                else if (hpos == 3) plen = {b, plen[7:0]};
                if (hpos < 3) begin
                    hpos = hpos + 1;
                end else begin
                    hpos = '0;
                    ppos = '0;
                    acc = '0;
                    note(length_error(opcode, {16'd0, plen}));
                    if (plen == 0) end_op();
                    else phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pos = {16'd0, ppos};
                acc = {b, acc[31:8]};
                if (pos[1:0] == 2'd3 && first_err == E_OK) check_payload_word(pos - 3, acc);
                if (pos + 1 >= {16'd0, plen}) end_op();
                else ppos = ppos + 1;
            end
            PH_TAIL: begin
                note(E_TRAILING);
                phase = PH_ERROR;
            end
            default: ;
        endcase
        if (!last) return 1'b0;
        case (phase)
            PH_HEADER:  v.code = E_SHORT;
            PH_OPHDR:   v.code = E_TRUNC_HDR;
            PH_PAYLOAD: v.code = E_TRUNC_PL;
            PH_TAIL:    v.code = E_OK;
            default:    v.code = first_err;
        endcase
        v.ok = (v.code == E_OK);
        clear_frame();
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_verdict v;
        t_verdict want;
        if (!i_rst_n) begin
            max_ops = DCFV_MAX_OPS_RESET;
            clear_frame();
            verdicts_due.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                ({1'b0, i_paddr[2]} == CFG_MAX_OPS[1:0]))
                max_ops = i_pwdata[19:0];
            if (i_s_tvalid && i_s_tready && parse_byte(i_s_tdata, i_s_tlast, v))
                verdicts_due.push_back(v);
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: verdict transfer 0x%02h with no frame ended",
                                 $realtime, i_m_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_m_tdata[0] !== want.ok || i_m_tdata[4:1] !== want.code) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected ok=%0b code=%0d, got ok=%0b code=%0d",
                                     $realtime, want.ok, want.code, i_m_tdata[0],
                                     i_m_tdata[4:1]);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= verdicts_due.size();
    end

endmodule

[dv/tb_draw_command_frame_validator.sv]
`timescale 1ns / 100ps
// Testbench top: frame stimulus, configuration phases, stalls and the final verdict.
module tb_draw_command_frame_validator;
    import dcfv_pkg::*;
    import dcfv_ops_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] MAX_OPS_ADDR = 3'(CFG_MAX_OPS * 4);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    logic        no_idle = 1'b0;
    logic        long_req = 1'b0;
    logic        long_seen = 1'b0;
    int          rx_wait = 0;
    int          quiet_cycles = 0;
    logic [7:0]  frame_bytes[$];
    logic [7:0]  op_pool[13] = '{OP_FIX20_A, OP_TEXT, OP_FIX24, OP_FIX20_B, OP_FIX28, OP_IMAGE,
                                 OP_FIX20_C, OP_FIX4_A, OP_BOX, OP_TEXT_RUN, OP_FIX12,
                                 OP_FIX4_B, OP_RECT_LIST};

    draw_command_frame_validator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    dcfv_verdict_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata), .i_s_tlast(s_tlast),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (long_req != long_seen) begin
            long_seen <= long_req;
            rx_wait <= 300;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rx_wait <= $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_draw_command_frame_validator: done, errors");
                $finish;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic last);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) put_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_max_ops(input logic [19:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_OPS_ADDR;
        pwdata <= {12'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_u32(input logic [31:0] w);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(w[8*i +: 8]);
    endtask

    function automatic logic [31:0] nonzero_word();
        logic [31:0] w;
        w = $urandom;
        return (w == 0) ? 32'd1 : w;
    endfunction

    task automatic start_frame(input logic [31:0] hdr_ops);
        frame_bytes.delete();
        add_u32(32'h3046474F);
        frame_bytes.push_back(8'd1);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'd40);
        frame_bytes.push_back(8'd0);
        add_u32(nonzero_word());
        add_u32(nonzero_word());
        add_u32(nonzero_word());
        add_u32(hdr_ops);
        add_u32($urandom);
        add_u32(nonzero_word());
        add_u32(nonzero_word());
        add_u32($urandom);
    endtask

    // Appends one operation with a well-formed payload for a known opcode; other opcodes get random bytes.
    task automatic add_op(input logic [7:0] opc);
        int k;
        int len;
        int w;
        int h;
        k = $urandom_range(0, 12);
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 4);
        case (opc)
            OP_FIX20_A, OP_FIX20_B, OP_FIX20_C: len = 20;
            OP_FIX24: len = 24;
            OP_FIX28: len = 28;
            OP_FIX12: len = 12;
            OP_FIX4_A, OP_FIX4_B: len = 4;
            OP_BOX: len = 36;
            OP_TEXT: len = 16 + k;
            OP_TEXT_RUN: len = 12 + k;
            OP_IMAGE: len = 16 + w * h * 4;
            OP_RECT_LIST: len = 8 + 32 * (k % 3 + 1);
            default: len = $urandom_range(0, 8);
        endcase
        frame_bytes.push_back(opc);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        for (int off = 0; off + 4 <= len; off += 4) begin
            if (opc == OP_TEXT && off == 12) add_u32(k);
            else if (opc == OP_TEXT_RUN && off == 8) add_u32(k);
            else if (opc == OP_IMAGE && off == 4) add_u32(w);
            else if (opc == OP_IMAGE && off == 8) add_u32(h);
            else if (opc == OP_IMAGE && off == 12) add_u32(w * h * 4);
            else if (opc == OP_BOX && (off == 12 || off == 16 || off == 28 || off == 32))
                add_u32(nonzero_word());
            else if (opc == OP_RECT_LIST && off == 4) add_u32(k % 3 + 1);
            else if (opc == OP_RECT_LIST && off >= 8 && ((off - 8) % 32) inside {8, 12, 24, 28})
                add_u32(nonzero_word());
            else add_u32($urandom);
        end
        for (int i = len & ~3; i < len; i++) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic random_frame(input int max_ops_in_frame);
        int n;
        int idx;
        int dims[5] = '{8, 12, 16, 28, 32};
        n = $urandom_range(0, max_ops_in_frame);
        start_frame(n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) add_op(8'($urandom));
            else add_op(op_pool[$urandom_range(0, 12)]);
        end
        case ($urandom_range(0, 11))
            0, 1: begin
                idx = $urandom_range(0, 1) ? $urandom_range(0, 39)
                                           : $urandom_range(0, frame_bytes.size() - 1);
                frame_bytes[idx] = 8'($urandom);
            end
            2: begin
                idx = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > idx) void'(frame_bytes.pop_back());
            end
            3: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            4: begin
                idx = dims[$urandom_range(0, 4)];
                for (int i = 0; i < 4; i++) frame_bytes[idx + i] = 8'd0;
            end
            5: begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 50)) frame_bytes.push_back(8'($urandom));
            end
            6: frame_bytes[20] = frame_bytes[20] ^ (8'd1 << $urandom_range(0, 7));
            default: ;
        endcase
        send_frame();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset limit.
        frame_bytes = '{8'h00};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
        start_frame(0);
        send_frame();
        start_frame(1);
        add_op(OP_TEXT);
        frame_bytes[56] = frame_bytes[56] + 8'd1;
        send_frame();
        start_frame(1);
        add_op(OP_IMAGE);
        frame_bytes[56] = frame_bytes[56] + 8'd4;
        send_frame();
        start_frame(1);
        add_op(OP_RECT_LIST);
        frame_bytes[48] = frame_bytes[48] + 8'd1;
        send_frame();
        start_frame(1);
        add_op(OP_BOX);
        for (int i = 56; i < 60; i++) frame_bytes[i] = 8'd0;
        send_frame();
        start_frame(2);
        add_op(8'd0);
        add_op(8'd255);
        send_frame();
        start_frame(1);
        add_op(OP_FIX20_A);
        frame_bytes[42] = 8'd21;
        frame_bytes.push_back(8'($urandom));
        send_frame();
        start_frame(1);
        add_op(OP_FIX4_A);
        frame_bytes[42] = 8'd0;
        frame_bytes[43] = 8'd0;
        void'(frame_bytes.pop_back());
        void'(frame_bytes.pop_back());
        void'(frame_bytes.pop_back());
        void'(frame_bytes.pop_back());
        send_frame();
        start_frame(2);
        add_op(OP_FIX12);
        send_frame();
        start_frame(1);
        add_op(OP_FIX28);
        void'(frame_bytes.pop_back());
        send_frame();
        start_frame(1);
        add_op(OP_FIX4_B);
        frame_bytes.push_back(8'h5A);
        send_frame();
        start_frame(0);
        frame_bytes[0] = 8'h00;
        frame_bytes[4] = 8'd2;
        send_frame();
        start_frame(0);
        frame_bytes[6] = 8'd41;
        send_frame();
        drain();

        write_max_ops(20'd0);
        random_frame(2);
        drain();

        write_max_ops(20'hFFFFF);
        start_frame(32'h100000);
        send_frame();
        start_frame(32'hFFFFF);
        send_frame();
        drain();

        // Hold the result side off while short frames pile up behind it.
        long_req <= ~long_req;
        repeat (20) begin
            frame_bytes = '{8'($urandom)};
            send_frame();
        end
        drain();

        write_max_ops(20'd3);
        no_idle <= 1'b1;
        repeat (2) random_frame(1);
        drain();

        if (fail_count == 0)
            $display("tb_draw_command_frame_validator: done, clean");
        else
            $display("tb_draw_command_frame_validator: done, errors");
        $finish;
    end

endmodule

[draw_command_frame_validator.f]
+incdir+rtl
rtl/dcfv_pkg.sv
rtl/dcfv_front.sv
rtl/dcfv_parse.sv
rtl/draw_command_frame_validator.sv
dv/dcfv_ops_pkg.sv
dv/dcfv_verdict_checker.sv
dv/tb_draw_command_frame_validator.sv
